@@ sv/smc_pkg.sv @@
`timescale 1ns / 1ps

package smc_pkg;

    // Marker geometry and field widths
    localparam int WIN_LEN = 32;
    localparam logic [WIN_LEN-1:0] MARKER_WORD = 32'h1ACF_FC1D;

    localparam int SOFT_W = 16;
    localparam int SUM_W  = 21;
    localparam int THR_W  = 19;
    localparam int POS_W  = 16;
    localparam int QUAL_W = 20;

    // 0.75 of full agreement (32 bits at amplitude 1.0)
    localparam logic [THR_W-1:0] THR_RESET = 19'd196608;

    typedef logic signed [SOFT_W-1:0] t_soft;
    typedef logic signed [SUM_W-1:0]  t_sum;

    // Step control for the correlator cells (the last cell ignores clr)
    typedef struct packed {
        logic en;   // a soft bit transfer happens this cycle
        logic clr;  // frame ends: partial sums restart at zero
    } t_chain_ctl;

endpackage

@@ sv/smc_cell.sv @@
`timescale 1ns / 1ps

module smc_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  smc_pkg::t_chain_ctl i_ctl,
    input  logic              i_coef,
    input  smc_pkg::t_soft    i_soft,
    input  smc_pkg::t_sum     i_psum,
    output smc_pkg::t_sum     o_psum
);
    import smc_pkg::*;

    t_sum w_ext;
    t_sum n_psum;
    t_sum r_psum;

    // Add or subtract the new soft bit depending on this cell's marker bit
    assign w_ext  = t_sum'(i_soft);
    assign n_psum = i_coef ? (i_psum + w_ext) : (i_psum - w_ext);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_psum <= '0;
        end else if (i_ctl.en) begin
            r_psum <= i_ctl.clr ? t_sum'(0) : n_psum;
        end
    end

    assign o_psum = r_psum;

endmodule

@@ sv/smc_chain.sv @@
`timescale 1ns / 1ps

// Transposed correlator: cell j holds the partial sum over the first j+1
// marker bits; the last cell holds the full window sum for the newest bit.
module smc_chain (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  smc_pkg::t_chain_ctl i_ctl,
    input  smc_pkg::t_soft      i_soft,
    output smc_pkg::t_sum       o_sum
);
    import smc_pkg::*;

    t_sum       w_psum [0:WIN_LEN];
    t_chain_ctl w_ctl_last;

    assign w_psum[0] = '0;

    // The final cell keeps the closing frame's sum so the peak stage can see it
    assign w_ctl_last.en  = i_ctl.en;
    assign w_ctl_last.clr = 1'b0;

    for (genvar j = 0; j < WIN_LEN; j++) begin : g_cell
        smc_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   ((j == WIN_LEN - 1) ? w_ctl_last : i_ctl),
            .i_coef  (MARKER_WORD[WIN_LEN-1-j]),
            .i_soft  (i_soft),
            .i_psum  (w_psum[j]),
            .o_psum  (w_psum[j+1])
        );
    end

    assign o_sum = w_psum[WIN_LEN];

endmodule

@@ sv/sync_marker_correlator.sv @@
`timescale 1ns / 1ps

// Soft-decision correlator for the 32-bit attached sync marker 0x1ACFFC1D.
// Slave stream: one signed soft bit per transfer (8192 = 1.0), tlast marks
// the final bit of a frame. Master stream: one result per frame, sent for
// the transfer that carried tlast: tuser = found, tdata = position and
// quality (best correlation sum, 262144 = full agreement).
// Configuration: i_cfg_wr_en writes the 19-bit acceptance threshold.
// Throughput: one soft bit per clock while the skid entry is free, sustained across frame boundaries.
// Path: the sum for the tlast transfer is registered in the last of the
// 32 correlator cells of the chain, then passes the combinational peak
// tracker into the output register that drives the master side.
// Stalls: an output register plus one skid entry sit behind the peak
// tracker; input is refused only while the skid entry is occupied, which
// needs two unsent results, i.e. a further frame ends while the receiver
// still holds tready low on the previous result.
// Reset clears the frame state and loads the threshold with 0.75 (196608).
// Windows that start beyond MAX_BITS-32 in a frame are not evaluated.
module sync_marker_correlator #(
    parameter int MAX_BITS = 65536
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_wr_en,
    input  logic [18:0] i_cfg_wr_data,   // accept_threshold
    // soft bit stream in
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,  // [15:0] soft_bit
    input  logic        i_s_axis_tlast,  // last
    // result stream out
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,  // [15:0] position, [35:16] quality, [39:36] zero
    output logic        o_m_axis_tuser   // found
);
    import smc_pkg::*;

    localparam int CNT_W = $clog2(MAX_BITS + 2);
    localparam logic [CNT_W-1:0] MAX_C = CNT_W'(MAX_BITS);
    localparam logic [CNT_W-1:0] WIN_C = CNT_W'(WIN_LEN);

    typedef struct packed {
        logic              found;
        logic [POS_W-1:0]  position;
        logic [QUAL_W-1:0] quality;
    } t_result;

    logic             w_acc;
    logic             w_adv;
    t_chain_ctl       w_ctl;
    t_sum             w_sum;

    logic [THR_W-1:0] r_thr;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    logic             r_s1_valid;
    logic             r_s1_last;
    logic             r_s1_eval;
    logic [POS_W-1:0] r_s1_start;

    logic [QUAL_W-1:0] r_best;
    logic [POS_W-1:0]  r_best_start;
    logic [QUAL_W-1:0] n_best;
    logic [POS_W-1:0]  n_best_start;
    logic              w_better;
    logic              w_res_valid;
    t_result           w_res;

    logic    r_out_valid;
    t_result r_out;
    logic    r_skid_valid;
    t_result r_skid;

    // Handshake: the whole pipeline moves unless the skid entry is occupied
    assign w_adv           = !r_skid_valid;
    assign o_s_axis_tready = w_adv;
    assign w_acc           = i_s_axis_tvalid && w_adv;

    // Threshold register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
        end else if (i_cfg_wr_en) begin
            r_thr <= i_cfg_wr_data;
        end
    end

    // Correlator chain
    assign w_ctl.en  = w_acc;
    assign w_ctl.clr = i_s_axis_tlast;

    smc_chain u_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_soft  (t_soft'(i_s_axis_tdata)),
        .o_sum   (w_sum)
    );

    // Bit counter, saturating one past MAX_BITS
    assign n_count = (r_count <= MAX_C) ? (r_count + 1'b1) : r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_acc) begin
            r_count <= i_s_axis_tlast ? '0 : n_count;
        end
    end

    // Stage 1 tags, aligned with the sum in the last cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_adv) begin
            r_s1_valid <= w_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_s1_last  <= i_s_axis_tlast;
            r_s1_eval  <= (n_count >= WIN_C) && (n_count <= MAX_C);
            r_s1_start <= POS_W'(n_count - WIN_C);
        end
    end

    // Peak tracker: earliest strictly larger positive sum wins
    assign w_better     = r_s1_eval && (w_sum > $signed({1'b0, r_best}));
    assign n_best       = w_better ? w_sum[QUAL_W-1:0] : r_best;
    assign n_best_start = w_better ? r_s1_start : r_best_start;

    assign w_res_valid    = w_adv && r_s1_valid && r_s1_last;
    assign w_res.found    = (n_best != '0) && (n_best >= {1'b0, r_thr});
    assign w_res.position = w_res.found ? n_best_start : '0;
    assign w_res.quality  = n_best;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best       <= '0;
            r_best_start <= '0;
        end else if (w_adv && r_s1_valid) begin
            if (r_s1_last) begin
                r_best       <= '0;
                r_best_start <= '0;
            end else begin
                r_best       <= n_best;
                r_best_start <= n_best_start;
            end
        end
    end

    // Output register with one skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_res_valid) begin
            if (!r_out_valid || i_m_axis_tready) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (r_skid_valid && i_m_axis_tready) begin
            r_skid_valid <= 1'b0;
        end else if (r_out_valid && i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid) begin
            if (!r_out_valid || i_m_axis_tready) begin
                r_out <= w_res;
            end else begin
                r_skid <= w_res;
            end
        end else if (r_skid_valid && i_m_axis_tready) begin
            r_out <= r_skid;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out.found;
    assign o_m_axis_tdata  = {4'b0000, r_out.quality, r_out.position};

    // Checks
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry occupied while output register empty");

    a_found_quality: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.found) |-> (r_out.quality != '0))
        else $error("marker reported with zero quality");

    a_pos_when_missing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.found) |-> (r_out.position == '0))
        else $error("nonzero position without a found marker");

    a_best_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_s1_valid && r_s1_last) |=> (r_best == '0))
        else $error("peak state not cleared after frame end");

endmodule
